// ===== rtl/core/dqe_pkg.sv =====
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared constants, codes and controller/datapath types for the deque block.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int DQE_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int KIND_W       = 2;

  // Request codes carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE      = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE       = 2'd3;

  // Result item kinds.
  localparam logic [KIND_W-1:0] KIND_FWD_HDR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REV_HDR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ELEM    = 2'd2;

  // How the datapath moves its walking index.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ERASE,
    IDX_FIRST,
    IDX_LAST,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef struct packed {
    logic               load_req;
    logic               ins_front;
    logic               ins_back;
    logic               set_drop;
    logic               dec_count;
    idx_op_e            idx_op;
    logic               rd_en;
    logic               rd_ahead;
    logic               shift_wr;
    logic               emit;
    logic [KIND_W-1:0]  kind;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             erase_ok;
    logic             erase_tail;
    logic             more_fwd;
    logic             more_shift;
    logic             idx_zero;
    logic             count_zero;
    logic             out_free;
  } sts_t;

endpackage

// ===== rtl/core/deque_indexed_erase_dump.sv =====
// ----------------------------------------------------------------------------
// deque_indexed_erase_dump
// Double-ended list with push front/back, erase at position, full dump.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state and decoded and applied in the
// execute state, then the block streams 2 + 2*count result items, one per
// cycle while the output is not stalled. The entries live in a ring buffer
// with one write and one registered read port; a push at either end is a
// single write, while an erase at position p moves the count-p-1 entries
// behind it one place forward, one entry per cycle through that read port,
// before the dump begins. A new request is taken only once the previous one
// has handed its last item to the output register.
// ----------------------------------------------------------------------------
module deque_indexed_erase_dump #(
  parameter int CAPACITY = dqe_pkg::DQE_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] operand
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] element
  output logic [2:0]  m_axis_tuser_o,   // [1:0] item_kind, [2] push_dropped
  output logic        m_axis_tlast_o    // last_of_run
);

  dqe_pkg::cmd_t cmd;
  dqe_pkg::sts_t sts;

  logic [dqe_pkg::KIND_W-1:0] out_kind;
  logic                       out_drop;

  dqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dqe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (s_axis_tuser_i),
    .operand_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_data_o  (m_axis_tdata_o),
    .out_drop_o  (out_drop),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {out_drop, out_kind};

endmodule

// ===== rtl/core/dqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqe_ctrl
// Sequencer: decodes a request, steps the erase shift and the two dump passes.
// ----------------------------------------------------------------------------
module dqe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dqe_pkg::sts_t sts_i,
  output dqe_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_HDR_F  = 3'd3;
  localparam logic [2:0] ST_ELEM_F = 3'd4;
  localparam logic [2:0] ST_HDR_R  = 3'd5;
  localparam logic [2:0] ST_ELEM_R = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_HDR_F;
        case (sts_i.req_type)
          dqe_pkg::REQ_PUSH_FRONT: begin
            if (sts_i.full) cmd_o.set_drop = 1'b1;
            else            cmd_o.ins_front = 1'b1;
          end
          dqe_pkg::REQ_PUSH_BACK: begin
            if (sts_i.full) cmd_o.set_drop = 1'b1;
            else            cmd_o.ins_back = 1'b1;
          end
          dqe_pkg::REQ_ERASE: begin
            if (sts_i.erase_ok) begin
              if (sts_i.erase_tail) begin
                cmd_o.dec_count = 1'b1;
              end else begin
                // Fetch the entry behind the erased one to start the shift.
                cmd_o.idx_op   = dqe_pkg::IDX_ERASE;
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_ahead = 1'b1;
                state_d        = ST_SHIFT;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.more_shift) begin
          cmd_o.idx_op   = dqe_pkg::IDX_INC;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_ahead = 1'b1;
        end else begin
          cmd_o.dec_count = 1'b1;
          state_d         = ST_HDR_F;
        end
      end
      ST_HDR_F: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dqe_pkg::KIND_FWD_HDR;
          if (sts_i.count_zero) begin
            state_d = ST_HDR_R;
          end else begin
            cmd_o.idx_op = dqe_pkg::IDX_FIRST;
            cmd_o.rd_en  = 1'b1;
            state_d      = ST_ELEM_F;
          end
        end
      end
      ST_ELEM_F: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dqe_pkg::KIND_ELEM;
          if (sts_i.more_fwd) begin
            cmd_o.idx_op = dqe_pkg::IDX_INC;
            cmd_o.rd_en  = 1'b1;
          end else begin
            state_d = ST_HDR_R;
          end
        end
      end
      ST_HDR_R: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dqe_pkg::KIND_REV_HDR;
          cmd_o.last = sts_i.count_zero;
          if (sts_i.count_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_op = dqe_pkg::IDX_LAST;
            cmd_o.rd_en  = 1'b1;
            state_d      = ST_ELEM_R;
          end
        end
      end
      ST_ELEM_R: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = dqe_pkg::KIND_ELEM;
          cmd_o.last = sts_i.idx_zero;
          if (sts_i.idx_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_op = dqe_pkg::IDX_DEC;
            cmd_o.rd_en  = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dqe_dpath.sv =====
// ----------------------------------------------------------------------------
// dqe_dpath
// Ring-buffer storage with head pointer and count, walking index, read
// register and the output register of the result stream.
// ----------------------------------------------------------------------------
module dqe_dpath #(
  parameter int CAPACITY = dqe_pkg::DQE_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dqe_pkg::cmd_t               cmd_i,
  output dqe_pkg::sts_t               sts_o,
  input  logic [dqe_pkg::REQ_W-1:0]   req_type_i,
  input  logic [dqe_pkg::DATA_W-1:0]  operand_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dqe_pkg::KIND_W-1:0]  out_kind_o,
  output logic [dqe_pkg::DATA_W-1:0]  out_data_o,
  output logic                        out_drop_o,
  output logic                        out_last_o
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH = 1 << PW;

  logic [dqe_pkg::DATA_W-1:0] mem [DEPTH];

  logic [PW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [dqe_pkg::REQ_W-1:0]    req_q;
  logic [dqe_pkg::DATA_W-1:0]   opnd_q;
  logic                         drop_q;
  logic [dqe_pkg::DATA_W-1:0]   rd_data_q;
  logic                         out_valid_q;
  logic [dqe_pkg::KIND_W-1:0]   out_kind_q;
  logic [dqe_pkg::DATA_W-1:0]   out_data_q;
  logic                         out_drop_q;
  logic                         out_last_q;

  logic [CW-1:0]                rd_idx;
  logic [PW-1:0]                rd_addr;
  logic                         wr_en;
  logic [PW-1:0]                wr_addr;
  logic [dqe_pkg::DATA_W-1:0]   wr_data;
  logic [CW-1:0]                pos;
  logic                         out_free;

  assign pos = opnd_q[CW-1:0];

  always_comb begin
    case (cmd_i.idx_op)
      dqe_pkg::IDX_ERASE: idx_d = pos;
      dqe_pkg::IDX_FIRST: idx_d = '0;
      dqe_pkg::IDX_LAST:  idx_d = count_q - CW'(1);
      dqe_pkg::IDX_INC:   idx_d = idx_q + CW'(1);
      dqe_pkg::IDX_DEC:   idx_d = idx_q - CW'(1);
      default:            idx_d = idx_q;
    endcase
  end

  // During the erase shift the read runs one entry ahead of the write.
  assign rd_idx  = idx_d + CW'(cmd_i.rd_ahead);
  assign rd_addr = head_q + rd_idx[PW-1:0];

  always_comb begin
    wr_en   = cmd_i.ins_front | cmd_i.ins_back | cmd_i.shift_wr;
    wr_data = cmd_i.shift_wr ? rd_data_q : opnd_q;
    if (cmd_i.ins_front) begin
      wr_addr = head_q - PW'(1);
    end else if (cmd_i.ins_back) begin
      wr_addr = head_q + count_q[PW-1:0];
    end else begin
      wr_addr = head_q + idx_q[PW-1:0];
    end
  end

  always_comb begin
    head_d  = cmd_i.ins_front ? head_q - PW'(1) : head_q;
    count_d = count_q;
    if (cmd_i.ins_front || cmd_i.ins_back) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.load_req) begin
        drop_q <= 1'b0;
      end else if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      opnd_q <= operand_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_last_q <= cmd_i.last;
      if (cmd_i.kind == dqe_pkg::KIND_ELEM) begin
        out_data_q <= rd_data_q;
        out_drop_q <= 1'b0;
      end else begin
        out_data_q <= '0;
        out_drop_q <= drop_q;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.req_type   = req_q;
    sts_o.full       = (count_q == CW'(CAPACITY));
    sts_o.erase_ok   = (opnd_q[dqe_pkg::DATA_W-1:CW] == '0) && (pos < count_q);
    sts_o.erase_tail = (pos == count_q - CW'(1));
    sts_o.more_fwd   = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q};
    sts_o.more_shift = ({1'b0, idx_q} + (CW+1)'(2)) < {1'b0, count_q};
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.count_zero = (count_q == '0);
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;
  assign out_drop_o  = out_drop_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/dqe_checker.sv =====
// ----------------------------------------------------------------------------
// dqe_checker
// Port-level checks on the deque block, bound to the top level.
// ----------------------------------------------------------------------------
module dqe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A result item held back by the consumer stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled result item changed");

  // Only one request is in work at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while the previous one is in work");

  // Headers carry a zero element.
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != dqe_pkg::KIND_ELEM) |->
      m_axis_tdata_o == '0)
    else $error("header item with non-zero element");

  // The dropped-push flag appears on headers only.
  a_elem_nodrop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] == dqe_pkg::KIND_ELEM) |->
      !m_axis_tuser_o[2])
    else $error("element item with push_dropped set");

  // A forward header is always followed by the reverse pass.
  a_fwd_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] == dqe_pkg::KIND_FWD_HDR) |->
      !m_axis_tlast_o)
    else $error("forward header marked as last item");

endmodule

bind deque_indexed_erase_dump dqe_checker u_dqe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the deque with indexed erase and full dump.
// ----------------------------------------------------------------------------
// Requests are streamed in from a queue with random gaps, and the result side
// stalls at random. A mirror of the list predicts both dump passes for every
// accepted request, and each result item is checked field by field against
// the oldest prediction. A short directed run covers the value extremes,
// every request code and the ignored erases. A biased random run then fills
// the list past full, drains it again and mixes the two.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP        = dqe_pkg::DQE_CAPACITY;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN_WAIT = 50;

  typedef struct packed {
    logic                       pause;
    logic [dqe_pkg::REQ_W-1:0]  req;
    logic [dqe_pkg::DATA_W-1:0] opnd;
  } request_t;

  typedef struct packed {
    logic [dqe_pkg::KIND_W-1:0] kind;
    logic [dqe_pkg::DATA_W-1:0] element;
    logic                       dropped;
    logic                       last;
  } dump_item_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [31:0]       s_axis_tdata_i  = '0;
  logic [1:0]        s_axis_tuser_i  = dqe_pkg::REQ_NONE;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [31:0]       m_axis_tdata_o;
  logic [2:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;

  request_t          req_q[$];
  dump_item_t        dump_q[$];
  request_t          next_req;
  dump_item_t        got_item;
  dump_item_t        want_item;

  logic [dqe_pkg::DATA_W-1:0] mirror_entries [CAP];
  logic [4:0]        mirror_count = '0;

  logic              in_taken     = 1'b0;
  int                cyc          = 0;
  int                quiet_cycles = 0;
  int                mismatches   = 0;
  int                n_requests   = 0;
  int                n_results    = 0;
  int                n_dropped    = 0;
  int                n_ignored    = 0;
  logic              calm;

  deque_indexed_erase_dump uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Inside this window of cycles the random request gaps and result stalls are off.
  assign calm = (cyc >= 1500) && (cyc < 3000);

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cyc, msg);
    mismatches++;
  endtask

  function automatic void add_dump(input dump_item_t item);
    dump_q.insert(dump_q.size(), item);
  endfunction

  // Applies one request to the mirror and queues the two passes it produces.
  task automatic predict_dump(input logic [dqe_pkg::REQ_W-1:0] req,
                              input logic [dqe_pkg::DATA_W-1:0] opnd);
    logic drop;
    drop = 1'b0;
    case (req)
      dqe_pkg::REQ_PUSH_FRONT, dqe_pkg::REQ_PUSH_BACK: begin
        if (mirror_count >= CAP) begin
          drop = 1'b1;
          n_dropped++;
        end else if (req == dqe_pkg::REQ_PUSH_FRONT) begin
          for (int i = mirror_count; i > 0; i--) mirror_entries[i] = mirror_entries[i-1];
          mirror_entries[0] = opnd;
          mirror_count++;
        end else begin
          mirror_entries[mirror_count] = opnd;
          mirror_count++;
        end
      end
      dqe_pkg::REQ_ERASE: begin
        // A set sign bit is a negative position and therefore out of range.
        if (!opnd[31] && opnd < mirror_count) begin
          for (int i = opnd; i + 1 < mirror_count; i++) mirror_entries[i] = mirror_entries[i+1];
          mirror_count--;
        end else begin
          n_ignored++;
        end
      end
      default: ;
    endcase
    add_dump(dump_item_t'{dqe_pkg::KIND_FWD_HDR, 32'd0, drop, 1'b0});
    for (int i = 0; i < mirror_count; i++)
      add_dump(dump_item_t'{dqe_pkg::KIND_ELEM, mirror_entries[i], 1'b0, 1'b0});
    add_dump(dump_item_t'{dqe_pkg::KIND_REV_HDR, 32'd0, drop, mirror_count == 0});
    for (int i = mirror_count; i > 0; i--)
      add_dump(dump_item_t'{dqe_pkg::KIND_ELEM, mirror_entries[i-1], 1'b0, i == 1});
  endtask

  function automatic void add_req(input logic [dqe_pkg::REQ_W-1:0] req,
                                  input logic [dqe_pkg::DATA_W-1:0] opnd);
    req_q.insert(req_q.size(), request_t'{1'b0, req, opnd});
  endfunction

  function automatic void add_pause();
    req_q.insert(req_q.size(), request_t'{1'b1, dqe_pkg::REQ_NONE, 32'd0});
  endfunction

  // Random block: push_pct of the requests are pushes, three quarters of the
  // rest are erases, mostly at positions near the live range.
  function automatic void add_random_block(input int count, input int push_pct);
    int pick;
    logic [dqe_pkg::DATA_W-1:0] val;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        case ($urandom_range(0, 9))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          default: val = $urandom();
        endcase
        add_req($urandom_range(0, 1) ? dqe_pkg::REQ_PUSH_BACK : dqe_pkg::REQ_PUSH_FRONT, val);
      end else if (pick < push_pct + (100 - push_pct) * 3 / 4) begin
        if ($urandom_range(0, 7) == 0) val = $urandom();
        else val = $urandom_range(0, CAP + 1);
        add_req(dqe_pkg::REQ_ERASE, val);
      end else begin
        add_req(dqe_pkg::REQ_NONE, $urandom());
      end
    end
  endfunction

  // Request driver: moves on only once the current item has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 25);
      if (!s_axis_tvalid_i || in_taken) begin
        if (req_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          next_req = req_q[0];
          if (next_req.pause) begin
            s_axis_tvalid_i <= 1'b0;
            if (dump_q.size() == 0) void'(req_q.pop_front());
          end else if (calm || $urandom_range(0, 99) >= 25) begin
            s_axis_tvalid_i <= 1'b1;
            s_axis_tuser_i  <= next_req.req;
            s_axis_tdata_i  <= next_req.opnd;
            void'(req_q.pop_front());
          end else begin
            s_axis_tvalid_i <= 1'b0;
          end
        end
      end
    end
  end

  // Monitor, predictor hook and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc      <= cyc + 1;
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        got_item = dump_item_t'{m_axis_tuser_o[1:0], m_axis_tdata_o, m_axis_tuser_o[2],
                                m_axis_tlast_o};
        if (dump_q.size() == 0) begin
          report_mismatch($sformatf("result item with none expected (kind %0d, data %h)",
                                    got_item.kind, got_item.element));
        end else begin
          want_item = dump_q.pop_front();
          if (got_item.kind !== want_item.kind)
            report_mismatch($sformatf("item_kind %0d, expected %0d",
                                      got_item.kind, want_item.kind));
          if (got_item.element !== want_item.element)
            report_mismatch($sformatf("element %h, expected %h",
                                      got_item.element, want_item.element));
          if (got_item.dropped !== want_item.dropped)
            report_mismatch($sformatf("push_dropped %b, expected %b",
                                      got_item.dropped, want_item.dropped));
          if (got_item.last !== want_item.last)
            report_mismatch($sformatf("tlast %b, expected %b",
                                      got_item.last, want_item.last));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        n_requests++;
        predict_dump(s_axis_tuser_i, s_axis_tdata_i);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no item moved for %0d cycles", QUIET_MAX);
        $display("[deque_indexed_erase_dump] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: empty list, value extremes, every request code, ignored erases.
    add_req(dqe_pkg::REQ_NONE,       32'h0000_0000);
    add_req(dqe_pkg::REQ_ERASE,      32'h0000_0000);
    add_req(dqe_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF);
    add_req(dqe_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    add_req(dqe_pkg::REQ_PUSH_BACK,  32'h0000_0000);
    add_req(dqe_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    add_req(dqe_pkg::REQ_ERASE,      32'h8000_0000);
    add_req(dqe_pkg::REQ_ERASE,      32'hFFFF_FFFF);
    add_req(dqe_pkg::REQ_ERASE,      32'd4);
    add_req(dqe_pkg::REQ_ERASE,      32'h7FFF_FFFF);
    add_req(dqe_pkg::REQ_ERASE,      32'd1);
    add_req(dqe_pkg::REQ_ERASE,      32'd2);
    add_req(dqe_pkg::REQ_ERASE,      32'd0);
    add_req(dqe_pkg::REQ_NONE,       32'h5A5A_5A5A);
    add_req(dqe_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    add_req(dqe_pkg::REQ_ERASE,      32'd1);
    add_req(dqe_pkg::REQ_ERASE,      32'd0);
    add_pause();
    // Random: fill past full, mix, refill, drain, mix.
    add_random_block(30, 85);
    add_random_block(30, 40);
    add_pause();
    add_random_block(30, 85);
    add_random_block(30, 15);
    add_pause();
    add_random_block(30, 45);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (req_q.size() != 0 || s_axis_tvalid_i);
    while (dump_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d requests and checked %0d result items", n_requests, n_results);
    $display("including %0d pushes into a full list and %0d out-of-range erases",
             n_dropped, n_ignored);
    if (mismatches == 0) begin
      $display("[deque_indexed_erase_dump] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[deque_indexed_erase_dump] ERROR");
    end
    $finish;
  end

endmodule

// ===== deque_indexed_erase_dump.f =====
rtl/core/dqe_pkg.sv
rtl/core/dqe_ctrl.sv
rtl/core/dqe_dpath.sv
rtl/core/deque_indexed_erase_dump.sv
rtl/core/dqe_checker.sv
dv/tb.sv
